### sv/ptq_pkg.sv
// Shared types, codes and constants of the periodic timer queue.
`timescale 1ns / 1ps

package ptq_pkg;

	localparam int NUM_TIMERS_DEF = 16;

	localparam int MODE_W   = 3;
	localparam int ID_W     = 32;
	localparam int IVL_W    = 32;
	localparam int TAG_W    = 16;
	localparam int TIME_W   = 64;
	localparam int STATUS_W = 2;

	// command codes
	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CHANGE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EXPIRE = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NONE_DUE  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_ACT,
		ST_DONE
	} state_t;

	// one timer slot as stored in the slot memory
	typedef struct packed {
		logic [ID_W-1:0]   ident;
		logic [TIME_W-1:0] due;
		logic [IVL_W-1:0]  interval;
		logic              periodic;
		logic [TAG_W-1:0]  tag;
	} slot_rec_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0]   timer_ident;
		logic [IVL_W-1:0]  interval;
		logic              periodic;
		logic [TAG_W-1:0]  handler_tag;
		logic [TIME_W-1:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     result_ident;
		logic [IVL_W-1:0]    time_remaining;
		logic [TAG_W-1:0]    fired_tag;
	} res_t;

	// write controls toward the slot store
	typedef struct packed {
		logic wr_en;
		logic vld_set;
		logic vld_clr;
	} store_wr_t;

endpackage

### sv/ptq_cmd_if.sv
// Command channel of the periodic timer queue.
`timescale 1ns / 1ps

interface ptq_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [ptq_pkg::MODE_W-1:0] mode;
	logic [ptq_pkg::ID_W-1:0]   timer_ident;
	logic [ptq_pkg::IVL_W-1:0]  interval;
	logic                       periodic;
	logic [ptq_pkg::TAG_W-1:0]  handler_tag;
	logic [ptq_pkg::TIME_W-1:0] now_time;

	modport source (
		output valid, mode, timer_ident, interval, periodic, handler_tag, now_time,
		input  ready
	);
	modport sink (
		input  valid, mode, timer_ident, interval, periodic, handler_tag, now_time,
		output ready
	);
endinterface

### sv/ptq_res_if.sv
// Result channel of the periodic timer queue.
`timescale 1ns / 1ps

interface ptq_res_if;
	logic                         valid;
	logic                         ready;
	logic [ptq_pkg::STATUS_W-1:0] status;
	logic [ptq_pkg::ID_W-1:0]     result_ident;
	logic [ptq_pkg::IVL_W-1:0]    time_remaining;
	logic [ptq_pkg::TAG_W-1:0]    fired_tag;

	modport source (
		output valid, status, result_ident, time_remaining, fired_tag,
		input  ready
	);
	modport sink (
		input  valid, status, result_ident, time_remaining, fired_tag,
		output ready
	);
endinterface

### sv/ptq_slot_store.sv
// Timer slot memory with per-slot valid bits and a registered read port.
`timescale 1ns / 1ps

module ptq_slot_store #(
	parameter  int NUM_TIMERS = ptq_pkg::NUM_TIMERS_DEF,
	localparam int IDX_W      = $clog2(NUM_TIMERS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output ptq_pkg::slot_rec_t  rd_rec,
	output logic                rd_slot_valid,
	input  ptq_pkg::store_wr_t  wr,
	input  logic [IDX_W-1:0]    wr_addr,
	input  ptq_pkg::slot_rec_t  wr_rec
);

	ptq_pkg::slot_rec_t     mem [NUM_TIMERS];
	ptq_pkg::slot_rec_t     rd_rec_q;
	logic [NUM_TIMERS-1:0]  valid_q;
	logic                   rd_vld_q;

	// valid bits live in flops so reset empties the table at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
			if (wr.vld_set) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (wr.vld_clr) begin
				valid_q[wr_addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem[wr_addr] <= wr_rec;
		end
		if (rd_en) begin
			rd_rec_q <= mem[rd_addr];
		end
	end

	assign rd_rec        = rd_rec_q;
	assign rd_slot_valid = rd_vld_q;

endmodule

### sv/periodic_timer_queue.sv
// Top level of the periodic timer queue: command sequencer around the slot store.
`timescale 1ns / 1ps

// Table of NUM_TIMERS software timers, one command per item on cmd and exactly
// one result item per command on res. Every command sweeps the whole slot memory,
// one slot per cycle through its single read port, then does at most one
// write-back; a new command is taken only after the result of the last one has
// been loaded into the output register. Add takes the lowest free slot and hands
// out sequential ids (wrapping at 2^32); cancel, change and time-left act on the
// lowest valid slot holding the id. Expire fires the earliest
// due timer, times compared as a wrap-aware signed 64-bit difference, ties going
// to the lowest slot; periodic timers re-arm by their interval, one-shots are freed.
// Time-left saturates at 2^32-1 and reports 0 once due. The result is held in an
// output register, so the next command is taken while a result waits on res.
// Reset empties the table at once (no clearing pass) and zeroes the id counter.

module periodic_timer_queue #(
	parameter int NUM_TIMERS = ptq_pkg::NUM_TIMERS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ptq_cmd_if.sink  cmd,
	ptq_res_if.source res
);

	localparam int IDX_W = $clog2(NUM_TIMERS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

	ptq_pkg::state_t    state_q, state_d;

	// sequencer strobes
	logic               in_ready;
	logic               scan_rd;
	logic               act;
	logic               load_out;

	// command and scan bookkeeping
	ptq_pkg::cmd_t      cmd_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic               chk_vld_s1;
	logic [IDX_W-1:0]   chk_idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   slot_q;
	ptq_pkg::slot_rec_t rec_q;
	logic [ptq_pkg::ID_W-1:0] next_ident_q;

	// result path
	ptq_pkg::res_t      res_d, res_hold_q, out_q;
	logic               out_valid_q;

	// slot store ports
	ptq_pkg::slot_rec_t rd_rec;
	logic               rd_slot_valid;
	ptq_pkg::store_wr_t wr;
	ptq_pkg::slot_rec_t wr_rec;

	// compare / arithmetic
	logic [ptq_pkg::TIME_W-1:0] best_diff;
	logic                       hit;
	logic [ptq_pkg::TIME_W-1:0] due_left;
	logic                       due_pos;
	logic [ptq_pkg::TIME_W-1:0] now_plus_ivl;
	logic [ptq_pkg::TIME_W-1:0] due_plus_ivl;
	logic                       cmd_acc;

	ptq_slot_store #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_en         (scan_rd),
		.rd_addr       (scan_idx_q),
		.rd_rec        (rd_rec),
		.rd_slot_valid (rd_slot_valid),
		.wr            (wr),
		.wr_addr       (slot_q),
		.wr_rec        (wr_rec)
	);

	assign cmd_acc = cmd.valid && in_ready;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptq_pkg::ST_IDLE:  begin
				if (cmd.valid) state_d = ptq_pkg::ST_SCAN;
			end
			ptq_pkg::ST_SCAN:  begin
				if (scan_idx_q == LAST_IDX) state_d = ptq_pkg::ST_DRAIN;
			end
			ptq_pkg::ST_DRAIN: state_d = ptq_pkg::ST_ACT;
			ptq_pkg::ST_ACT:   state_d = ptq_pkg::ST_DONE;
			ptq_pkg::ST_DONE:  begin
				if (!out_valid_q || res.ready) state_d = ptq_pkg::ST_IDLE;
			end
			default:           state_d = ptq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		scan_rd  = 1'b0;
		act      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ptq_pkg::ST_IDLE:  in_ready = 1'b1;
			ptq_pkg::ST_SCAN:  scan_rd  = 1'b1;
			ptq_pkg::ST_DRAIN: ;
			ptq_pkg::ST_ACT:   act      = 1'b1;
			ptq_pkg::ST_DONE:  load_out = !out_valid_q || res.ready;
			default:           ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- scan compare ----------------
	// read data of slot chk_idx_s1 comes from the registered read port in the cycle after its address went out
	assign best_diff = rd_rec.due - rec_q.due;

	always_comb begin
		hit = 1'b0;
		case (cmd_q.mode)
			ptq_pkg::MODE_ADD:    hit = !found_q && !rd_slot_valid;
			ptq_pkg::MODE_CANCEL,
			ptq_pkg::MODE_CHANGE,
			ptq_pkg::MODE_QUERY:  hit = !found_q && rd_slot_valid &&
			                            (rd_rec.ident == cmd_q.timer_ident);
			// strictly earlier only, so ties keep the lower slot
			ptq_pkg::MODE_EXPIRE: hit = rd_slot_valid &&
			                            (!found_q || best_diff[ptq_pkg::TIME_W-1]);
			default:              hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			chk_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			next_ident_q <= '0;
		end else begin
			chk_vld_s1 <= scan_rd;
			if (cmd_acc) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (scan_rd) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (chk_vld_s1 && hit) begin
				found_q <= 1'b1;
			end
			if (act && found_q && (cmd_q.mode == ptq_pkg::MODE_ADD)) begin
				next_ident_q <= next_ident_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q.mode        <= cmd.mode;
			cmd_q.timer_ident <= cmd.timer_ident;
			cmd_q.interval    <= cmd.interval;
			cmd_q.periodic    <= cmd.periodic;
			cmd_q.handler_tag <= cmd.handler_tag;
			cmd_q.now_time    <= cmd.now_time;
		end
		chk_idx_s1 <= scan_idx_q;
		if (chk_vld_s1 && hit) begin
			slot_q <= chk_idx_s1;
			rec_q  <= rd_rec;
		end
		if (act) begin
			res_hold_q <= res_d;
		end
	end

	// ---------------- write-back and result ----------------
	assign due_left     = rec_q.due - cmd_q.now_time;
	assign due_pos      = (due_left != '0) && !due_left[ptq_pkg::TIME_W-1];
	assign now_plus_ivl = cmd_q.now_time + {{(ptq_pkg::TIME_W-ptq_pkg::IVL_W){1'b0}},
	                                        cmd_q.interval};
	assign due_plus_ivl = rec_q.due + {{(ptq_pkg::TIME_W-ptq_pkg::IVL_W){1'b0}},
	                                   rec_q.interval};

	always_comb begin
		wr     = '0;
		wr_rec = rec_q;
		res_d  = '0;
		case (cmd_q.mode)
			ptq_pkg::MODE_ADD: begin
				if (found_q) begin
					wr.wr_en            = act;
					wr.vld_set          = act;
					wr_rec.ident        = next_ident_q;
					wr_rec.due          = now_plus_ivl;
					wr_rec.interval     = cmd_q.interval;
					wr_rec.periodic     = cmd_q.periodic;
					wr_rec.tag          = cmd_q.handler_tag;
					res_d.result_ident  = next_ident_q;
				end else begin
					res_d.status = ptq_pkg::STAT_FULL;
				end
			end
			ptq_pkg::MODE_CANCEL: begin
				if (found_q) wr.vld_clr = act;
				else         res_d.status = ptq_pkg::STAT_NOT_FOUND;
			end
			ptq_pkg::MODE_CHANGE: begin
				if (found_q) begin
					wr.wr_en        = act;
					wr_rec.due      = now_plus_ivl;
					wr_rec.interval = cmd_q.interval;
					wr_rec.periodic = cmd_q.periodic;
				end else begin
					res_d.status = ptq_pkg::STAT_NOT_FOUND;
				end
			end
			ptq_pkg::MODE_QUERY: begin
				if (!found_q) begin
					res_d.status = ptq_pkg::STAT_NOT_FOUND;
				end else if (due_pos) begin
					// saturate anything beyond 32 bits
					res_d.time_remaining = (|due_left[ptq_pkg::TIME_W-1:ptq_pkg::IVL_W]) ?
						'1 : due_left[ptq_pkg::IVL_W-1:0];
				end
			end
			ptq_pkg::MODE_EXPIRE: begin
				if (!found_q || due_pos) begin
					res_d.status = ptq_pkg::STAT_NONE_DUE;
				end else begin
					res_d.result_ident = rec_q.ident;
					res_d.fired_tag    = rec_q.tag;
					if (rec_q.periodic) begin
						wr.wr_en   = act;
						wr_rec.due = due_plus_ivl;
					end else begin
						wr.vld_clr = act;
					end
				end
			end
			default: ;
		endcase
	end

	// output register decouples res from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_hold_q;
		end
	end

	assign cmd.ready          = in_ready;
	assign res.valid          = out_valid_q;
	assign res.status         = out_q.status;
	assign res.result_ident   = out_q.result_ident;
	assign res.time_remaining = out_q.time_remaining;
	assign res.fired_tag      = out_q.fired_tag;

endmodule
